// File: hdl/ihc_pkg.sv
// Shared types and constants for the index header checker.
// Used by the front end, the token queue, the back end and the top level.
// No dependencies.
package ihc_pkg;

   // Header marker word that selects little-endian tables
   localparam logic [15:0] LE_MARKER = 16'h8001;

   // Token queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Table word index: both tables hold at most 2 * 65535 words
   localparam int IDX_W = 17;
   // Payload start: header plus 4 bytes per entry
   localparam int PAY_W = 19;
   // Compressed total plus payload start, and target offset
   localparam int SUM_W = 33;

   localparam logic [PAY_W-1:0] HDR_SHORT = PAY_W'(2);
   localparam logic [PAY_W-1:0] HDR_LONG  = PAY_W'(4);
   localparam logic [31:0]      MIN_ABS   = 32'd2;
   localparam logic [31:0]      MIN_LE    = 32'd4;

   // Register indexes on the csr channel
   localparam logic [1:0] CSR_FILE_SIZE   = 2'd0;
   localparam logic [1:0] CSR_TARGET      = 2'd1;
   localparam logic [1:0] CSR_COUNT_LIMIT = 2'd2;
   localparam logic [1:0] CSR_MIN_BYTES   = 2'd3;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_TOO_SMALL = 2'd1,
      ST_BAD_COUNT = 2'd2,
      ST_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ES_OK       = 2'd0,
      ES_RANGE    = 2'd1,
      ES_SPAN     = 2'd2,
      ES_NOT_EVAL = 2'd3
   } entry_status_type;

   // What the front end decoded from one byte
   typedef enum logic [2:0] {
      TK_SKIP   = 3'd0,
      TK_FIRST  = 3'd1,
      TK_MARKER = 3'd2,
      TK_COUNT  = 3'd3,
      TK_WORD   = 3'd4
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type     kind;
      logic             last;
      logic [15:0]      word;
      logic [IDX_W-1:0] idx;
   } tok_type;

   typedef struct packed {
      logic [31:0] file_size;
      logic [15:0] target_entry;
      logic [15:0] count_limit;
      logic [15:0] min_file_bytes;
   } cfg_type;

   // Result item; last member sits in the lowest bits
   typedef struct packed {
      logic [15:0]      entry_decompressed;
      logic [15:0]      entry_compressed;
      logic [31:0]      entry_offset;
      logic [15:0]      largest_decompressed;
      logic [15:0]      largest_compressed;
      logic [31:0]      sum_decompressed;
      logic [31:0]      sum_compressed;
      logic [PAY_W-1:0] payload_start;
      logic [15:0]      entry_count;
      logic             little_endian;
      entry_status_type entry_status;
      status_type       status;
   } rsp_type;

endpackage

// File: hdl/ihc_front.sv
// Front end: tracks byte position, pairs bytes into words, classifies them.
// Depends on ihc_pkg for the token type and header constants.
module ihc_front
   import ihc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic       req_tlast,   // last_byte
   output logic       push_valid,
   input  logic       push_ready,
   output tok_type    push_tok
);

   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_HDR2,
      PH_HDR3,
      PH_TABLE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic             marker_ff, marker_in;
   logic             odd_ff, odd_in;
   logic [7:0]       held_ff, held_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             accept;

   assign req_tready = push_ready;
   assign push_valid = req_tvalid;
   assign accept     = req_tvalid & push_ready;

   // Decode the current byte and advance the position
   always_comb begin
      phase_in      = phase_ff;
      marker_in     = marker_ff;
      odd_in        = odd_ff;
      idx_in        = idx_ff;
      held_in       = req_tdata;
      push_tok.kind = TK_SKIP;
      push_tok.last = req_tlast;
      push_tok.word = {held_ff, req_tdata};
      push_tok.idx  = idx_ff;
      case (phase_ff)
         PH_HDR0: begin
            push_tok.kind = TK_FIRST;
            phase_in      = PH_HDR1;
         end
         PH_HDR1: begin
            if ({held_ff, req_tdata} == LE_MARKER) begin
               push_tok.kind = TK_MARKER;
               marker_in     = 1'b1;
               phase_in      = PH_HDR2;
            end else begin
               push_tok.kind = TK_COUNT;
               phase_in      = PH_TABLE;
            end
         end
         PH_HDR2: begin
            phase_in = PH_HDR3;
         end
         PH_HDR3: begin
            push_tok.kind = TK_COUNT;
            push_tok.word = {req_tdata, held_ff};
            phase_in      = PH_TABLE;
         end
         PH_TABLE: begin
            if (odd_ff) begin
               push_tok.kind = TK_WORD;
               push_tok.word = marker_ff ? {req_tdata, held_ff} : {held_ff, req_tdata};
               idx_in        = idx_ff + IDX_W'(1);
               odd_in        = 1'b0;
            end else begin
               odd_in = 1'b1;
            end
         end
         default: begin
            phase_in = PH_HDR0;
         end
      endcase
      // End of archive: back to the start of the next one
      if (req_tlast) begin
         phase_in  = PH_HDR0;
         marker_in = 1'b0;
         odd_in    = 1'b0;
         idx_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         marker_ff <= 1'b0;
         odd_ff    <= 1'b0;
         idx_ff    <= '0;
         held_ff   <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         marker_ff <= marker_in;
         odd_ff    <= odd_in;
         idx_ff    <= idx_in;
         held_ff   <= held_in;
      end
   end

endmodule

// File: hdl/ihc_queue.sv
// Short token queue between front end and back end.
// Depends on ihc_pkg for the token type and queue depth.
module ihc_queue
   import ihc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  tok_type push_tok,
   output logic    pop_valid,
   input  logic    pop_ready,
   output tok_type pop_tok
);

   tok_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_tok    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid & push_ready;
   assign do_pop     = pop_valid & pop_ready;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + QPTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

endmodule

// File: hdl/ihc_back.sv
// Back end: header checks, size table totals, target span, result register.
// Depends on ihc_pkg for token, configuration and result types.
module ihc_back
   import ihc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    tok_valid,
   output logic    tok_ready,
   input  tok_type tok,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output rsp_type rsp_tdata
);

   logic             decided_ff, decided_in;
   logic             marker_ff, marker_in;
   logic [15:0]      count_ff, count_in;
   logic [PAY_W-1:0] pay_ff, pay_in;
   logic [31:0]      ctot_ff, ctot_in;
   logic [31:0]      dtot_ff, dtot_in;
   logic [15:0]      cpeak_ff, cpeak_in;
   logic [15:0]      dpeak_ff, dpeak_in;
   logic [SUM_W-1:0] cp_ff, cp_in;     // compressed total plus payload start
   logic [SUM_W-1:0] off_ff, off_in;   // payload start plus sizes before target
   logic [15:0]      tc_ff, tc_in;
   logic [15:0]      td_ff, td_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff, rsp_in;

   logic             pop, load_rsp, fail, ok;
   status_type       fail_code;
   logic [PAY_W-1:0] pay_new;
   logic [SUM_W:0]   cp_sum, span_end;
   logic [IDX_W-1:0] dec_idx;

   assign tok_ready  = ~rsp_valid_ff | rsp_tready;
   assign pop        = tok_valid & tok_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   always_comb begin
      pay_new = (marker_ff ? HDR_LONG : HDR_SHORT) + {1'b0, tok.word, 2'b00};
      cp_sum  = {1'b0, cp_ff} + (SUM_W + 1)'(tok.word);
      dec_idx = tok.idx - {1'b0, count_ff};
   end

   // Stream state update for one token
   always_comb begin
      decided_in = decided_ff;
      marker_in  = marker_ff;
      count_in   = count_ff;
      pay_in     = pay_ff;
      ctot_in    = ctot_ff;
      dtot_in    = dtot_ff;
      cpeak_in   = cpeak_ff;
      dpeak_in   = dpeak_ff;
      cp_in      = cp_ff;
      off_in     = off_ff;
      tc_in      = tc_ff;
      td_in      = td_ff;
      fail       = 1'b0;
      fail_code  = ST_TOO_SMALL;
      ok         = 1'b0;
      if (!decided_ff) begin
         case (tok.kind)
            TK_FIRST: begin
               if (cfg.file_size < 32'(cfg.min_file_bytes) || cfg.file_size < MIN_ABS) begin
                  fail = 1'b1;
               end
            end
            TK_MARKER: begin
               marker_in = 1'b1;
               if (cfg.file_size < MIN_LE) begin
                  fail = 1'b1;
               end
            end
            TK_COUNT: begin
               count_in = tok.word;
               pay_in   = pay_new;
               cp_in    = SUM_W'(pay_new);
               off_in   = SUM_W'(pay_new);
               if (tok.word == '0 || tok.word > cfg.count_limit) begin
                  fail      = 1'b1;
                  fail_code = ST_BAD_COUNT;
               end else if (32'(pay_new) > cfg.file_size) begin
                  fail = 1'b1;
               end
            end
            TK_WORD: begin
               if (tok.idx < {1'b0, count_ff}) begin
                  // compressed table
                  ctot_in = ctot_ff + 32'(tok.word);
                  cp_in   = cp_sum[SUM_W-1:0];
                  if (tok.word > cpeak_ff) cpeak_in = tok.word;
                  if (tok.idx < {1'b0, cfg.target_entry}) begin
                     off_in = off_ff + SUM_W'(tok.word);
                  end
                  if (tok.idx == {1'b0, cfg.target_entry}) tc_in = tok.word;
                  if (cp_sum > (SUM_W + 1)'(cfg.file_size)) begin
                     fail      = 1'b1;
                     fail_code = ST_OVERFLOW;
                  end
               end else begin
                  // decompressed table
                  dtot_in = dtot_ff + 32'(tok.word);
                  if (tok.word > dpeak_ff) dpeak_in = tok.word;
                  if (dec_idx == {1'b0, cfg.target_entry}) td_in = tok.word;
               end
               if (!fail && ({1'b0, tok.idx} + (IDX_W + 1)'(1)) >= {1'b0, count_ff, 1'b0}) begin
                  ok = 1'b1;
               end
            end
            default: begin
            end
         endcase
         // Archive ended before the outcome was known
         if (tok.last && !fail && !ok) begin
            fail      = 1'b1;
            fail_code = ST_TOO_SMALL;
         end
      end
      decided_in = decided_in | fail | ok;
   end

   assign load_rsp = pop & (fail | ok);
   assign span_end = {1'b0, off_in} + (SUM_W + 1)'(tc_in);

   // Result assembly
   always_comb begin
      rsp_in              = '0;
      rsp_in.status       = fail ? fail_code : ST_OK;
      rsp_in.entry_status = ES_NOT_EVAL;
      if (!fail) begin
         rsp_in.little_endian        = marker_in;
         rsp_in.entry_count          = count_in;
         rsp_in.payload_start        = pay_in;
         rsp_in.sum_compressed       = ctot_in;
         rsp_in.sum_decompressed     = dtot_in;
         rsp_in.largest_compressed   = cpeak_in;
         rsp_in.largest_decompressed = dpeak_in;
         if (cfg.target_entry >= count_in) begin
            rsp_in.entry_status = ES_RANGE;
         end else if (span_end > (SUM_W + 1)'(cfg.file_size)) begin
            rsp_in.entry_status = ES_SPAN;
         end else begin
            rsp_in.entry_status       = ES_OK;
            rsp_in.entry_offset       = off_in[31:0];
            rsp_in.entry_compressed   = tc_in;
            rsp_in.entry_decompressed = td_in;
         end
      end
   end

   // Stream state; cleared by the last byte of an archive
   always_ff @(posedge clock) begin
      if (reset) begin
         decided_ff <= 1'b0;
         marker_ff  <= 1'b0;
         count_ff   <= '0;
         pay_ff     <= '0;
         ctot_ff    <= '0;
         dtot_ff    <= '0;
         cpeak_ff   <= '0;
         dpeak_ff   <= '0;
         cp_ff      <= '0;
         off_ff     <= '0;
         tc_ff      <= '0;
         td_ff      <= '0;
      end else if (pop) begin
         if (tok.last) begin
            decided_ff <= 1'b0;
            marker_ff  <= 1'b0;
            count_ff   <= '0;
            pay_ff     <= '0;
            ctot_ff    <= '0;
            dtot_ff    <= '0;
            cpeak_ff   <= '0;
            dpeak_ff   <= '0;
            cp_ff      <= '0;
            off_ff     <= '0;
            tc_ff      <= '0;
            td_ff      <= '0;
         end else begin
            decided_ff <= decided_in;
            marker_ff  <= marker_in;
            count_ff   <= count_in;
            pay_ff     <= pay_in;
            ctot_ff    <= ctot_in;
            dtot_ff    <= dtot_in;
            cpeak_ff   <= cpeak_in;
            dpeak_ff   <= dpeak_in;
            cp_ff      <= cp_in;
            off_ff     <= off_in;
            tc_ff      <= tc_in;
            td_ff      <= td_in;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

`ifndef SYNTHESIS
   // The last byte always leaves the stream undecided for the next archive
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      pop && tok.last |=> !decided_ff)
      else $error("stream state not cleared after last byte");

   // At most one result per archive
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> !decided_ff)
      else $error("second result for one archive");

   // A failed result carries nothing but its status
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != ST_OK |->
         rsp_ff.entry_status == ES_NOT_EVAL && rsp_ff.entry_count == '0)
      else $error("failed result carries stale fields");
`endif

endmodule

// File: hdl/graphics_index_header_checker.sv
// Top level of the index header checker: csr registers, front, queue, back.
// The deciding byte passes the token queue, then the result register.
// Throughput: one byte per cycle; a result waiting on rsp stalls the back end,
// and the 4-entry token queue lets the front take bytes until it is full.
// Reset is synchronous, active high; csr registers return to their defaults.
// Depends on ihc_pkg, ihc_front, ihc_queue and ihc_back.
module graphics_index_header_checker
   import ihc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, entry_status, little_endian, entry_count, payload_start,
   // sum_compressed, sum_decompressed, largest_compressed,
   // largest_decompressed, entry_offset, entry_compressed, entry_decompressed
   output logic [199:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   cfg_type cfg_ff;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   tok_type push_tok, pop_tok;
   rsp_type rsp_word;

   assign csr_ready = 1'b1;
   assign rsp_tdata = rsp_word;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.file_size      <= '0;
         cfg_ff.target_entry   <= '0;
         cfg_ff.count_limit    <= 16'd8192;
         cfg_ff.min_file_bytes <= 16'd2;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FILE_SIZE:   cfg_ff.file_size      <= csr_data;
            CSR_TARGET:      cfg_ff.target_entry   <= csr_data[15:0];
            CSR_COUNT_LIMIT: cfg_ff.count_limit    <= csr_data[15:0];
            CSR_MIN_BYTES:   cfg_ff.min_file_bytes <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   ihc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok)
   );

   ihc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_tok   (push_tok),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_tok    (pop_tok)
   );

   ihc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tok_valid  (pop_valid),
      .tok_ready  (pop_ready),
      .tok        (pop_tok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_word)
   );

endmodule

// File: tb/tb_graphics_index_header_checker.sv
// Self-checking testbench for graphics_index_header_checker: streams archive bytes,
// predicts each header verdict in a local model and checks every result transfer.
// Depends on ihc_pkg and the graphics_index_header_checker top level.
module tb_graphics_index_header_checker;
   import ihc_pkg::*;

   localparam int unsigned ITEM_TARGET   = 1800;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 500000;
   localparam int unsigned PRINT_CAP     = 40;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;    // [7:0] data_byte
   logic         req_tlast;    // last_byte
   logic         rsp_tvalid;
   logic         rsp_tready;
   // status, entry_status, little_endian, entry_count, payload_start,
   // sum_compressed, sum_decompressed, largest_compressed,
   // largest_decompressed, entry_offset, entry_compressed, entry_decompressed
   logic [199:0] rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;

   graphics_index_header_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Register copy and stream state of the local model
   cfg_type     regs;
   logic [31:0] pos_q;
   logic [7:0]  held_q;
   logic        le_q;
   logic [15:0] count_q;
   logic [31:0] csum_q;
   logic [31:0] dsum_q;
   logic [15:0] cpeak_q;
   logic [15:0] dpeak_q;
   logic [31:0] before_q;
   logic [15:0] tcomp_q;
   logic [15:0] tdecomp_q;
   logic        done_q;

   rsp_type     pending_verdicts [$];
   rsp_type     seen_verdict;
   rsp_type     want_verdict;
   int unsigned mismatch_count;
   int unsigned bytes_sent;
   int unsigned cycle_count;
   int unsigned src_idle_pct;
   int unsigned snk_idle_pct;

   // Directed table: register writes and bytes, some with a typed verdict
   typedef struct {
      bit          is_csr;
      logic [1:0]  index;
      logic [31:0] value;
      logic [7:0]  data;
      logic        last;
      bit          typed;
      status_type  code;
   } plan_row_type;
   plan_row_type plan [$];
   logic [7:0]   archive_q [$];

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic void clear_stream();
      pos_q = '0; held_q = '0; le_q = 1'b0; count_q = '0;
      csum_q = '0; dsum_q = '0; cpeak_q = '0; dpeak_q = '0;
      before_q = '0; tcomp_q = '0; tdecomp_q = '0; done_q = 1'b0;
   endfunction

   function automatic logic [63:0] payload_base();
      return (le_q ? 64'd4 : 64'd2) + 64'd4 * count_q;
   endfunction

   function automatic rsp_type fail_result(input status_type code);
      rsp_type v;
      v = '0;
      v.status = code;
      v.entry_status = ES_NOT_EVAL;
      return v;
   endfunction

   function automatic rsp_type ok_result();
      rsp_type     v;
      logic [63:0] pay;
      logic [63:0] off;
      logic [63:0] fs;
      pay = payload_base();
      fs = {32'd0, regs.file_size};
      v = '0;
      v.status = ST_OK;
      v.entry_status = ES_OK;
      v.little_endian = le_q;
      v.entry_count = count_q;
      v.payload_start = pay[PAY_W-1:0];
      v.sum_compressed = csum_q;
      v.sum_decompressed = dsum_q;
      v.largest_compressed = cpeak_q;
      v.largest_decompressed = dpeak_q;
      if (regs.target_entry >= count_q) begin
         v.entry_status = ES_RANGE;
      end else begin
         off = pay + before_q;
         if (off > fs || {48'd0, tcomp_q} > fs - off) begin
            v.entry_status = ES_SPAN;
         end else begin
            v.entry_offset = off[31:0];
            v.entry_compressed = tcomp_q;
            v.entry_decompressed = tdecomp_q;
         end
      end
      return v;
   endfunction

   // Zero count, count above the limit, or tables past the end of the file
   function automatic bit count_verdict(output rsp_type v);
      v = '0;
      if (count_q == 16'd0 || count_q > regs.count_limit) begin
         v = fail_result(ST_BAD_COUNT);
         return 1'b1;
      end
      if (payload_base() > {32'd0, regs.file_size}) begin
         v = fail_result(ST_TOO_SMALL);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit digest_byte(input logic [7:0] b, output rsp_type v);
      logic [15:0] first;
      logic [15:0] w;
      logic [31:0] rel;
      logic [31:0] idx;
      logic [31:0] j;
      logic [63:0] pay;
      v = '0;
      if (pos_q == 32'd0) begin
         if (regs.file_size < regs.min_file_bytes || regs.file_size < MIN_ABS) begin
            v = fail_result(ST_TOO_SMALL);
            return 1'b1;
         end
         return 1'b0;
      end
      if (pos_q == 32'd1) begin
         first = {held_q, b};
         if (first == LE_MARKER) begin
            le_q = 1'b1;
            if (regs.file_size < MIN_LE) begin
               v = fail_result(ST_TOO_SMALL);
               return 1'b1;
            end
            return 1'b0;
         end
         count_q = first;
         return count_verdict(v);
      end
      if (le_q && pos_q == 32'd2) return 1'b0;
      if (le_q && pos_q == 32'd3) begin
         count_q = {b, held_q};
         return count_verdict(v);
      end
      // Table words complete on odd offsets past the header
      rel = pos_q - (le_q ? 32'd4 : 32'd2);
      if (!rel[0]) return 1'b0;
      w = le_q ? {b, held_q} : {held_q, b};
      idx = rel >> 1;
      if (idx < count_q) begin
         pay = payload_base();
         csum_q = csum_q + w;
         if (w > cpeak_q) cpeak_q = w;
         if (idx < regs.target_entry) before_q = before_q + w;
         if (idx == regs.target_entry) tcomp_q = w;
         if (pay > {32'd0, regs.file_size} ||
             {32'd0, csum_q} > {32'd0, regs.file_size} - pay) begin
            v = fail_result(ST_OVERFLOW);
            return 1'b1;
         end
      end else begin
         j = idx - count_q;
         dsum_q = dsum_q + w;
         if (w > dpeak_q) dpeak_q = w;
         if (j == regs.target_entry) tdecomp_q = w;
      end
      if ({32'd0, rel} + 64'd1 >= 64'd4 * count_q) begin
         v = ok_result();
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // One accepted byte; returns 1 when it yields a verdict
   function automatic bit predict_header_byte(input logic [7:0] b, input logic l,
                                              output rsp_type v);
      bit hit;
      hit = 1'b0;
      v = '0;
      if (!done_q) begin
         hit = digest_byte(b, v);
         if (hit) done_q = 1'b1;
      end
      if (l) begin
         // Early end before a decision
         if (!done_q) begin
            v = fail_result(ST_TOO_SMALL);
            hit = 1'b1;
         end
         clear_stream();
      end else begin
         held_q = b;
         pos_q = pos_q + 32'd1;
      end
      return hit;
   endfunction

   // ---------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic compare_verdict(input rsp_type got, input rsp_type want);
      check_field("status", got.status, want.status);
      check_field("entry_status", got.entry_status, want.entry_status);
      check_field("little_endian", got.little_endian, want.little_endian);
      check_field("entry_count", got.entry_count, want.entry_count);
      check_field("payload_start", got.payload_start, want.payload_start);
      check_field("sum_compressed", got.sum_compressed, want.sum_compressed);
      check_field("sum_decompressed", got.sum_decompressed, want.sum_decompressed);
      check_field("largest_compressed", got.largest_compressed, want.largest_compressed);
      check_field("largest_decompressed", got.largest_decompressed,
                  want.largest_decompressed);
      check_field("entry_offset", got.entry_offset, want.entry_offset);
      check_field("entry_compressed", got.entry_compressed, want.entry_compressed);
      check_field("entry_decompressed", got.entry_decompressed, want.entry_decompressed);
   endtask

   // Result side: random backpressure and in-order check of each transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            seen_verdict = rsp_type'(rsp_tdata);
            if (pending_verdicts.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_tdata[63:0], 64'd0);
            end else begin
               want_verdict = pending_verdicts.pop_front();
               compare_verdict(seen_verdict, want_verdict);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("graphics_index_header_checker regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers
   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_FILE_SIZE:   regs.file_size = value;
         CSR_TARGET:      regs.target_entry = value[15:0];
         CSR_COUNT_LIMIT: regs.count_limit = value[15:0];
         CSR_MIN_BYTES:   regs.min_file_bytes = value[15:0];
         default: ;
      endcase
   endtask

   // Stop sending and let every pending verdict come out before a register write
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] d, input logic l, input bit typed,
                            input status_type code);
      int unsigned gap;
      bit          hit;
      rsp_type     v;
      // Idle profile follows the share of bytes sent so far
      if (bytes_sent < ITEM_TARGET / 3) begin
         src_idle_pct = 35; snk_idle_pct = 85;
      end else if (bytes_sent < 2 * ITEM_TARGET / 3) begin
         src_idle_pct = 85; snk_idle_pct = 35;
      end else begin
         src_idle_pct = 0; snk_idle_pct = 0;
      end
      gap = 0;
      while (gap < 16 && $urandom_range(0, 99) < src_idle_pct) gap++;
      csr_valid <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= l;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      hit = predict_header_byte(d, l, v);
      if (typed) pending_verdicts.push_back(fail_result(code));
      else if (hit) pending_verdicts.push_back(v);
   endtask

   function automatic void plan_csr(input logic [1:0] index, input logic [31:0] value);
      plan_row_type p;
      p = '{is_csr: 1'b0, index: 2'd0, value: 32'd0, data: 8'd0, last: 1'b0,
            typed: 1'b0, code: ST_OK};
      p.is_csr = 1'b1;
      p.index = index;
      p.value = value;
      plan.push_back(p);
   endfunction

   function automatic void plan_byte(input logic [7:0] d, input logic l, input bit typed,
                                     input status_type code);
      plan_row_type p;
      p = '{is_csr: 1'b0, index: 2'd0, value: 32'd0, data: 8'd0, last: 1'b0,
            typed: 1'b0, code: ST_OK};
      p.data = d;
      p.last = l;
      p.typed = typed;
      p.code = code;
      plan.push_back(p);
   endfunction

   function automatic logic [15:0] pick_size();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 30));
      if (r < 80) return 16'hFFFF;
      if (r < 90) return 16'($urandom_range(0, 65535));
      return 16'd0;
   endfunction

   // One archive: mostly well formed, some truncated, some plain noise
   task automatic build_archive();
      int unsigned r;
      int unsigned count;
      int unsigned k;
      int unsigned len;
      bit          le;
      logic [15:0] w;
      archive_q.delete();
      r = $urandom_range(0, 99);
      if (r < 8) begin
         len = $urandom_range(1, 12);
         repeat (len) archive_q.push_back(8'($urandom_range(0, 255)));
         return;
      end
      le = ($urandom_range(0, 2) == 0);
      r = $urandom_range(0, 99);
      if (r < 80)      count = $urandom_range(1, 5);
      else if (r < 88) count = 0;
      else if (r < 94) count = $urandom_range(6, 12);
      else             count = $urandom_range(13, 65535);
      if (le) begin
         archive_q.push_back(LE_MARKER[15:8]);
         archive_q.push_back(LE_MARKER[7:0]);
         archive_q.push_back(8'(count));
         archive_q.push_back(8'(count >> 8));
      end else begin
         archive_q.push_back(8'(count >> 8));
         archive_q.push_back(8'(count));
      end
      if (count > 12) begin
         // Header alone decides; keep the rest short
         repeat ($urandom_range(0, 8)) archive_q.push_back(8'($urandom_range(0, 255)));
      end else begin
         for (k = 0; k < 2 * count; k++) begin
            w = pick_size();
            if (le) begin
               archive_q.push_back(w[7:0]);
               archive_q.push_back(w[15:8]);
            end else begin
               archive_q.push_back(w[15:8]);
               archive_q.push_back(w[7:0]);
            end
         end
         repeat ($urandom_range(0, 3)) archive_q.push_back(8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 9) == 0) begin
         len = $urandom_range(1, archive_q.size());
         while (archive_q.size() > len) void'(archive_q.pop_back());
      end
   endtask

   task automatic configure_phase();
      int unsigned r;
      logic [31:0] fs;
      logic [15:0] target;
      logic [15:0] limit;
      logic [15:0] min_bytes;
      r = $urandom_range(0, 9);
      if (r == 0)      fs = 32'hFFFF_FFFF;
      else if (r == 1) fs = $urandom;
      else if (r == 2) fs = $urandom_range(0, 4);
      else             fs = $urandom_range(0, 200);
      r = $urandom_range(0, 9);
      if (r == 0)      target = 16'hFFFF;
      else if (r == 1) target = 16'($urandom_range(0, 65535));
      else             target = 16'($urandom_range(0, 6));
      r = $urandom_range(0, 19);
      if (r < 3)       limit = 16'($urandom_range(1, 8));
      else if (r < 5)  limit = 16'hFFFF;
      else if (r == 5) limit = 16'd1;
      else             limit = 16'd8192;
      r = $urandom_range(0, 19);
      if (r < 14)      min_bytes = 16'd2;
      else if (r < 17) min_bytes = 16'($urandom_range(2, 250));
      else if (r == 17) min_bytes = 16'hFFFF;
      else             min_bytes = 16'($urandom_range(2, 65535));
      csr_write(CSR_FILE_SIZE, fs);
      csr_write(CSR_TARGET, {16'd0, target});
      csr_write(CSR_COUNT_LIMIT, {16'd0, limit});
      csr_write(CSR_MIN_BYTES, {16'd0, min_bytes});
   endtask

   // ---------------------------------------------------------------- stimulus
   initial begin : stimulus
      int unsigned i;
      int unsigned k;
      clock = 1'b0;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      mismatch_count = 0;
      bytes_sent = 0;
      cycle_count = 0;
      src_idle_pct = 35;
      snk_idle_pct = 85;
      regs.file_size = 32'd0;
      regs.target_entry = 16'd0;
      regs.count_limit = 16'd8192;
      regs.min_file_bytes = 16'd2;
      clear_stream();

      // After reset the file size is zero, below the minimum
      plan_byte(8'hFF, 1'b1, 1'b1, ST_TOO_SMALL);
      // Marker word with a file shorter than the long header
      plan_csr(CSR_FILE_SIZE, 32'd3);
      plan_byte(8'h80, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h01, 1'b0, 1'b1, ST_TOO_SMALL);
      plan_byte(8'h00, 1'b1, 1'b0, ST_OK);
      // Zero count, then a count above the limit
      plan_csr(CSR_FILE_SIZE, 32'd100);
      plan_csr(CSR_COUNT_LIMIT, 32'd2);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h00, 1'b0, 1'b1, ST_BAD_COUNT);
      plan_byte(8'h55, 1'b1, 1'b0, ST_OK);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h03, 1'b1, 1'b1, ST_BAD_COUNT);
      // Tables do not fit in the file
      plan_csr(CSR_COUNT_LIMIT, 32'hFFFF);
      plan_csr(CSR_FILE_SIZE, 32'd5);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h01, 1'b1, 1'b1, ST_TOO_SMALL);
      // Big-endian archive that exactly fills its payload space
      plan_csr(CSR_FILE_SIZE, 32'd10);
      plan_csr(CSR_TARGET, 32'd0);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h01, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h04, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h07, 1'b1, 1'b0, ST_OK);
      // Stream ends before a decision
      plan_byte(8'h12, 1'b1, 1'b1, ST_TOO_SMALL);
      // Largest minimum size
      plan_csr(CSR_MIN_BYTES, 32'hFFFF);
      plan_byte(8'hAA, 1'b1, 1'b1, ST_TOO_SMALL);
      // Little-endian archive, largest sizes, target out of range
      plan_csr(CSR_MIN_BYTES, 32'd2);
      plan_csr(CSR_FILE_SIZE, 32'hFFFF_FFFF);
      plan_csr(CSR_TARGET, 32'hFFFF);
      plan_byte(8'h80, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h01, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h01, 1'b0, 1'b0, ST_OK);
      plan_byte(8'h00, 1'b0, 1'b0, ST_OK);
      plan_byte(8'hFF, 1'b0, 1'b0, ST_OK);
      plan_byte(8'hFF, 1'b0, 1'b0, ST_OK);
      plan_byte(8'hFF, 1'b0, 1'b0, ST_OK);
      plan_byte(8'hFF, 1'b1, 1'b0, ST_OK);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (i = 0; i < plan.size(); i++) begin
         if (plan[i].is_csr) begin
            if (i == 0 || !plan[i-1].is_csr) wait_drained();
            csr_write(plan[i].index, plan[i].value);
         end else begin
            send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].code);
         end
      end

      // Random phases: settings change only once the block has drained
      while (bytes_sent < ITEM_TARGET) begin
         wait_drained();
         configure_phase();
         repeat ($urandom_range(2, 6)) begin
            build_archive();
            for (k = 0; k < archive_q.size(); k++)
               send_byte(archive_q[k], k == archive_q.size() - 1, 1'b0, ST_OK);
         end
      end

      req_tvalid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
         $display("graphics_index_header_checker regression: pass");
      end else begin
         $display("graphics_index_header_checker regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
hdl/ihc_pkg.sv
hdl/ihc_front.sv
hdl/ihc_queue.sv
hdl/ihc_back.sv
hdl/graphics_index_header_checker.sv
tb/tb_graphics_index_header_checker.sv
